@@ src/utt_pkg.sv @@
`default_nettype none

package utt_pkg;

    // Result group: every byte that one input transfer gives, in order
    localparam int GRP_DEPTH = 6;
    localparam int GRP_CNT_W = $clog2(GRP_DEPTH + 1);

    typedef struct packed {
        logic [GRP_DEPTH-1:0][7:0] data;
        logic [GRP_CNT_W-1:0]      cnt;
        logic                      marker;   // bare end marker, no data byte
        logic                      eof;
    } grp_t;

    // One encoded code point, at most four bytes
    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } enc_t;

    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_LE   = 2'd1;
    localparam logic [1:0] MODE_BE   = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;
    localparam logic [7:0] BOM_FF = 8'hFF;
    localparam logic [7:0] BOM_FE = 8'hFE;

    localparam logic [15:0] SURR_HI_MIN = 16'hD800;
    localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
    localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h10000;

    localparam logic [20:0] CP_LIM_1 = 21'h80;
    localparam logic [20:0] CP_LIM_2 = 21'h800;
    localparam logic [20:0] CP_LIM_3 = 21'h10000;

    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;
    localparam logic [7:0] CONT   = 8'h80;

    function automatic enc_t utf8_encode(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < CP_LIM_1) begin
            e.b[0] = cp[7:0];
            e.n    = 3'd1;
        end
        else if (cp < CP_LIM_2) begin
            e.b[0] = LEAD_2 | {3'b000, cp[10:6]};
            e.b[1] = CONT | {2'b00, cp[5:0]};
            e.n    = 3'd2;
        end
        else if (cp < CP_LIM_3) begin
            e.b[0] = LEAD_3 | {4'b0000, cp[15:12]};
            e.b[1] = CONT | {2'b00, cp[11:6]};
            e.b[2] = CONT | {2'b00, cp[5:0]};
            e.n    = 3'd3;
        end
        else begin
            e.b[0] = LEAD_4 | {5'b00000, cp[20:18]};
            e.b[1] = CONT | {2'b00, cp[17:12]};
            e.b[2] = CONT | {2'b00, cp[11:6]};
            e.b[3] = CONT | {2'b00, cp[5:0]};
            e.n    = 3'd4;
        end
        return e;
    endfunction

    // Append one byte; a full group drops it
    function automatic grp_t grp_push(input grp_t g, input logic [7:0] b);
        grp_t r;
        r = g;
        if (g.cnt < GRP_CNT_W'(GRP_DEPTH)) begin
            r.data[g.cnt] = b;
            r.cnt         = GRP_CNT_W'(g.cnt + 1'b1);
        end
        return r;
    endfunction

    function automatic grp_t grp_push_cp(input grp_t g, input logic [20:0] cp);
        grp_t r;
        enc_t e;
        r = g;
        e = utf8_encode(cp);
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < e.n) begin
                r = grp_push(r, e.b[i]);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/utt_step.sv @@
`default_nettype none

// Stream state and the per-transfer decode into a result group
module utt_step (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_wr,
    input  wire logic [1:0]    cfg_mode,
    input  wire logic          fire,
    input  wire logic [7:0]    item_byte,
    input  wire logic          item_end,
    output utt_pkg::grp_t      grp
);
    import utt_pkg::*;

    typedef enum logic [3:0] {
        PH_DETECT = 4'b0001,
        PH_PASS   = 4'b0010,
        PH_LE     = 4'b0100,
        PH_BE     = 4'b1000
    } phase_t;

    function automatic phase_t start_phase(input logic [1:0] mode);
        phase_t p;
        case (mode)
            MODE_AUTO: p = PH_DETECT;
            MODE_LE:   p = PH_LE;
            MODE_BE:   p = PH_BE;
            default:   p = PH_PASS;
        endcase
        return p;
    endfunction

    logic [1:0] mode_reg;
    phase_t     phase_reg, phase_next;
    logic [1:0] hc_reg, hc_next;
    logic       held_valid_reg, held_valid_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] head0_reg, head0_next;
    logic [7:0] head1_reg, head1_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic [9:0] pend_high_reg, pend_high_next;

    grp_t        g;
    logic [15:0] unit;
    logic        done;

    always_comb
    begin
        g               = '0;
        unit            = '0;
        done            = 1'b0;
        phase_next      = phase_reg;
        hc_next         = hc_reg;
        held_valid_next = held_valid_reg;
        pend_valid_next = pend_valid_reg;
        head0_next      = head0_reg;
        head1_next      = head1_reg;
        held_byte_next  = held_byte_reg;
        pend_high_next  = pend_high_reg;

        case (phase_reg)
            PH_DETECT:
            begin
                if (hc_reg == 2'd0) begin
                    if (item_byte inside {BOM_EF, BOM_FF, BOM_FE}) begin
                        head0_next = item_byte;
                        hc_next    = 2'd1;
                    end
                    else begin
                        g          = grp_push(g, item_byte);
                        phase_next = PH_PASS;
                    end
                end
                else if (hc_reg == 2'd1) begin
                    if (head0_reg == BOM_EF && item_byte == BOM_BB) begin
                        head1_next = item_byte;
                        hc_next    = 2'd2;
                    end
                    else if (head0_reg == BOM_FF && item_byte == BOM_FE) begin
                        phase_next = PH_LE;
                        hc_next    = 2'd0;
                    end
                    else if (head0_reg == BOM_FE && item_byte == BOM_FF) begin
                        phase_next = PH_BE;
                        hc_next    = 2'd0;
                    end
                    else begin
                        g          = grp_push(g, head0_reg);
                        g          = grp_push(g, item_byte);
                        phase_next = PH_PASS;
                        hc_next    = 2'd0;
                    end
                end
                else begin
                    if (item_byte != BOM_BF) begin
                        g = grp_push(g, head0_reg);
                        g = grp_push(g, head1_reg);
                        g = grp_push(g, item_byte);
                    end
                    phase_next = PH_PASS;
                    hc_next    = 2'd0;
                end
                // End inside an unfinished mark: flush the held start bytes
                if (item_end && hc_next != 2'd0) begin
                    g = grp_push(g, head0_next);
                    if (hc_next == 2'd2) begin
                        g = grp_push(g, head1_next);
                    end
                    hc_next = 2'd0;
                end
            end
            PH_LE, PH_BE:
            begin
                if (!held_valid_reg) begin
                    held_byte_next  = item_byte;
                    held_valid_next = 1'b1;
                    if (item_end && pend_valid_reg) begin
                        pend_valid_next = 1'b0;
                        g = grp_push_cp(g, 21'(SURR_HI_MIN) | 21'(pend_high_reg));
                    end
                end
                else begin
                    held_valid_next = 1'b0;
                    unit = (phase_reg == PH_BE) ? {held_byte_reg, item_byte}
                                                : {item_byte, held_byte_reg};
                    if (pend_valid_reg) begin
                        pend_valid_next = 1'b0;
                        if (unit inside {[SURR_LO_MIN:SURR_LO_MAX]}) begin
                            g = grp_push_cp(g, CP_SUPP_BASE
                                               + {1'b0, pend_high_reg, unit[9:0]});
                            done = 1'b1;
                        end
                        else begin
                            g = grp_push_cp(g, 21'(SURR_HI_MIN) | 21'(pend_high_reg));
                        end
                    end
                    if (!done) begin
                        if (unit inside {[SURR_HI_MIN:SURR_HI_MAX]} && !item_end) begin
                            pend_high_next  = unit[9:0];
                            pend_valid_next = 1'b1;
                        end
                        else begin
                            g = grp_push_cp(g, 21'(unit));
                        end
                    end
                end
            end
            default:
            begin
                g = grp_push(g, item_byte);
            end
        endcase

        if (item_end) begin
            if (g.cnt == '0) begin
                g.cnt    = GRP_CNT_W'(1);
                g.marker = 1'b1;
            end
            g.eof           = 1'b1;
            phase_next      = start_phase(mode_reg);
            hc_next         = 2'd0;
            held_valid_next = 1'b0;
            pend_valid_next = 1'b0;
        end
    end

    assign grp = g;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_AUTO;
            phase_reg      <= PH_DETECT;
            hc_reg         <= 2'd0;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (cfg_wr) begin
            mode_reg       <= cfg_mode;
            phase_reg      <= start_phase(cfg_mode);
            hc_reg         <= 2'd0;
            held_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (fire) begin
            phase_reg      <= phase_next;
            hc_reg         <= hc_next;
            held_valid_reg <= held_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) begin
            head0_reg     <= head0_next;
            head1_reg     <= head1_next;
            held_byte_reg <= held_byte_next;
            pend_high_reg <= pend_high_next;
        end
    end

endmodule

`default_nettype wire

@@ src/utt_serial.sv @@
`default_nettype none

// Hold one result group and drain it a byte per transfer into the output register
module utt_serial (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire utt_pkg::grp_t grp,
    output logic               take_ok,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               byte_valid,
    output logic               last_of_run,
    output logic               end_of_file
);
    import utt_pkg::*;

    grp_t                 g_reg;
    logic                 g_valid_reg;
    logic [GRP_CNT_W-1:0] idx_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       last_reg;
    logic       end_of_file_reg;

    logic out_free;
    logic move;
    logic g_last;
    logic load;

    assign out_free = !out_valid_reg || !out_stall;
    assign move     = g_valid_reg && out_free;
    assign g_last   = (idx_reg == GRP_CNT_W'(g_reg.cnt - 1'b1));
    assign take_ok  = !g_valid_reg || (move && g_last);
    assign load     = fire && (grp.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            g_valid_reg   <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (load) begin
                g_valid_reg <= 1'b1;
                idx_reg     <= '0;
            end
            else if (move) begin
                if (g_last) begin
                    g_valid_reg <= 1'b0;
                end
                idx_reg <= GRP_CNT_W'(idx_reg + 1'b1);
            end
            if (out_free) begin
                out_valid_reg <= move;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            g_reg <= grp;
        end
        if (move) begin
            out_byte_reg    <= g_reg.data[idx_reg];
            byte_valid_reg  <= !g_reg.marker;
            last_reg        <= g_last;
            end_of_file_reg <= g_reg.eof && g_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign last_of_run = last_reg;
    assign end_of_file = end_of_file_reg;

`ifndef SYNTHESIS
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        g_valid_reg |-> (idx_reg < g_reg.cnt))
        else $error("drain index beyond group");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!g_valid_reg || (move && g_last)))
        else $error("group loaded while not drained");

    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (g_valid_reg && g_reg.marker) |-> (g_reg.cnt == GRP_CNT_W'(1) && g_reg.eof))
        else $error("end marker not a lone end-of-file result");

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && end_of_file_reg) |-> last_reg)
        else $error("end of file off the last result of a run");
`endif

endmodule

`default_nettype wire

@@ src/utf16_to_utf8_transcoder_core.sv @@
`default_nettype none

// UTF-16 to UTF-8 transcoder. Raw file bytes enter one per transfer, stream_end
// on the last; UTF-8 bytes leave one per transfer. In auto mode a leading EF BB BF,
// FF FE or FE FF mark selects UTF-8, UTF-16LE or UTF-16BE and is dropped; any
// other start passes through as it is. UTF-16 units are paired from bytes,
// surrogate pairs are joined, lone surrogates become three-byte sequences and an
// odd trailing byte is dropped. Each input byte yields zero to six output bytes;
// the final result of each input is flagged by last_of_run, the final result of
// the file by end_of_file, and a file end that yields no byte gives one bare
// marker with byte_valid low. Writing input_mode restarts the stream; write it
// only while no transfer is in flight. An input byte passes an input register, is
// decoded combinationally into a result group held in the group register, and
// the group drains through the output register at one byte per cycle while
// out_stall is low. The output port sets the rate, so pass-through runs at one
// byte per cycle while out_stall is low.
module utf16_to_utf8_transcoder_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       input_mode_wr,
    input  wire logic [1:0] input_mode,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       stream_end,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            last_of_run,
    output logic            end_of_file
);
    import utt_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;

    logic  take_ok;
    logic  fire;
    logic  accept;
    grp_t  grp;

    // Decode the held byte once the group register can take its results
    assign fire     = in_valid_reg && take_ok;
    assign in_stall = in_valid_reg && !take_ok;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end
        else if (accept) begin
            in_valid_reg <= 1'b1;
        end
        else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Hold the payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (accept) begin
            in_byte_reg <= in_byte;
            in_end_reg  <= stream_end;
        end
    end

    // Stream state and decode
    utt_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (input_mode_wr),
        .cfg_mode  (input_mode),
        .fire      (fire),
        .item_byte (in_byte_reg),
        .item_end  (in_end_reg),
        .grp       (grp)
    );

    // Drain each group through the output register
    utt_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .grp         (grp),
        .take_ok     (take_ok),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .last_of_run (last_of_run),
        .end_of_file (end_of_file)
    );

endmodule

`default_nettype wire

@@ tb/utf16_to_utf8_transcoder_core_tb.sv @@
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_core_tb;

    import utt_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest
    // legitimate quiet stretch is a receiver hold-off.
    localparam int unsigned QUIET_LIMIT = 2000;

    // Number of input transfers after which the random part stops
    localparam int unsigned ITEM_TARGET = 320;

    // Cycles to let pass after the last result before a register write. An
    // input byte may still be in flight that gives no result at all.
    localparam int unsigned SETTLE_CYCLES = 10;

    // Stream phase as the block sees it
    typedef enum logic [1:0] {
        PH_DETECT,
        PH_PASS,
        PH_LE,
        PH_BE
    } phase_t;

    // One output transfer, as it should appear on the result port
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       eof;
    } utf8_beat_t;

    // Unit values at the edges of the UTF-8 length classes and surrogate ranges
    localparam logic [15:0] EDGE_UNITS [12] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
        16'hD800, 16'hDBFF, 16'hDC00, 16'hDFFF, 16'hE000, 16'hFFFF
    };

    // Scoreboard: tracks the transcoder state, turns each accepted input byte
    // into the UTF-8 transfers it should cause, and checks the result port.
    class utf8_scoreboard;
        logic [1:0]  mode;
        phase_t      phase;
        logic [7:0]  head [2];
        int unsigned head_cnt;
        logic [7:0]  held;
        bit          held_ok;
        logic [9:0]  pend_hi;
        bit          pend_ok;
        utf8_beat_t  step_beats [$];
        utf8_beat_t  bytes_due [$];
        int unsigned errors;

        function new();
            mode    = MODE_AUTO;
            head[0] = 8'h00;
            head[1] = 8'h00;
            held    = 8'h00;
            pend_hi = 10'd0;
            errors  = 0;
            restart_stream();
        endfunction

        function void restart_stream();
            case (mode)
                MODE_AUTO: phase = PH_DETECT;
                MODE_LE:   phase = PH_LE;
                MODE_BE:   phase = PH_BE;
                default:   phase = PH_PASS;
            endcase
            head_cnt = 0;
            held_ok  = 1'b0;
            pend_ok  = 1'b0;
        endfunction

        function void set_mode(input logic [1:0] m);
            mode = m;
            restart_stream();
        endfunction

        // A step carries at most six bytes; anything beyond is lost
        function void put_byte(input logic [7:0] b);
            if (step_beats.size() < GRP_DEPTH)
                step_beats.insert(step_beats.size(), utf8_beat_t'{b, 1'b1, 1'b0, 1'b0});
        endfunction

        function void put_code_point(input logic [20:0] cp);
            if (cp < CP_LIM_1) begin
                put_byte(cp[7:0]);
            end
            else if (cp < CP_LIM_2) begin
                put_byte(LEAD_2 | {3'b000, cp[10:6]});
                put_byte(CONT | {2'b00, cp[5:0]});
            end
            else if (cp < CP_LIM_3) begin
                put_byte(LEAD_3 | {4'b0000, cp[15:12]});
                put_byte(CONT | {2'b00, cp[11:6]});
                put_byte(CONT | {2'b00, cp[5:0]});
            end
            else begin
                put_byte(LEAD_4 | {5'b00000, cp[20:18]});
                put_byte(CONT | {2'b00, cp[17:12]});
                put_byte(CONT | {2'b00, cp[11:6]});
                put_byte(CONT | {2'b00, cp[5:0]});
            end
        endfunction

        function void put_lone_high();
            put_code_point(21'(SURR_HI_MIN | {6'd0, pend_hi}));
        endfunction

        function void detect_head(input logic [7:0] b, input bit fin);
            if (head_cnt == 0) begin
                if (b == BOM_EF || b == BOM_FF || b == BOM_FE) begin
                    head[0]  = b;
                    head_cnt = 1;
                end
                else begin
                    put_byte(b);
                    phase = PH_PASS;
                end
            end
            else if (head_cnt == 1) begin
                if (head[0] == BOM_EF && b == BOM_BB) begin
                    head[1]  = b;
                    head_cnt = 2;
                end
                else if (head[0] == BOM_FF && b == BOM_FE) begin
                    phase    = PH_LE;
                    head_cnt = 0;
                end
                else if (head[0] == BOM_FE && b == BOM_FF) begin
                    phase    = PH_BE;
                    head_cnt = 0;
                end
                else begin
                    put_byte(head[0]);
                    put_byte(b);
                    phase    = PH_PASS;
                    head_cnt = 0;
                end
            end
            else begin
                if (b != BOM_BF) begin
                    put_byte(head[0]);
                    put_byte(head[1]);
                    put_byte(b);
                end
                phase    = PH_PASS;
                head_cnt = 0;
            end
            // a file that ends inside a partial mark gives the held bytes back
            if (fin && head_cnt != 0) begin
                put_byte(head[0]);
                if (head_cnt >= 2)
                    put_byte(head[1]);
                head_cnt = 0;
            end
        endfunction

        function void pair_units(input logic [7:0] b, input bit fin, input bit big);
            logic [15:0] unit;
            if (!held_ok) begin
                held    = b;
                held_ok = 1'b1;
                // odd trailing byte is dropped, a waiting high surrogate is not
                if (fin && pend_ok) begin
                    pend_ok = 1'b0;
                    put_lone_high();
                end
                return;
            end
            held_ok = 1'b0;
            unit    = big ? {held, b} : {b, held};
            if (pend_ok) begin
                pend_ok = 1'b0;
                if (unit >= SURR_LO_MIN && unit <= SURR_LO_MAX) begin
                    put_code_point(CP_SUPP_BASE + {1'b0, pend_hi, 10'd0}
                                   + 21'(unit - SURR_LO_MIN));
                    return;
                end
                put_lone_high();
            end
            if (unit >= SURR_HI_MIN && unit <= SURR_HI_MAX && !fin) begin
                pend_hi = 10'(unit - SURR_HI_MIN);
                pend_ok = 1'b1;
            end
            else begin
                put_code_point({5'd0, unit});
            end
        endfunction

        function void note_transfer(input logic [7:0] b, input bit fin);
            utf8_beat_t tail;
            step_beats.delete();
            case (phase)
                PH_DETECT: detect_head(b, fin);
                PH_LE:     pair_units(b, fin, 1'b0);
                PH_BE:     pair_units(b, fin, 1'b1);
                default:   put_byte(b);
            endcase
            if (fin && step_beats.size() == 0)
                step_beats.insert(0, utf8_beat_t'{8'h00, 1'b0, 1'b0, 1'b0});
            if (step_beats.size() > 0) begin
                tail      = step_beats[step_beats.size() - 1];
                tail.last = 1'b1;
                tail.eof  = fin;
                step_beats[step_beats.size() - 1] = tail;
            end
            foreach (step_beats[i])
                bytes_due.insert(bytes_due.size(), step_beats[i]);
            if (fin)
                restart_stream();
        endfunction

        task report_mismatch(input string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_transfer(input logic [7:0] d, input logic v, input logic l,
                            input logic e);
            utf8_beat_t want;
            if (bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result byte %02h valid %0b", d, v));
                return;
            end
            want = bytes_due.pop_front();
            if (d !== want.data)
                report_mismatch($sformatf("out_byte %02h, want %02h", d, want.data));
            if (v !== want.valid)
                report_mismatch($sformatf("byte_valid %0b, want %0b", v, want.valid));
            if (l !== want.last)
                report_mismatch($sformatf("last_of_run %0b, want %0b", l, want.last));
            if (e !== want.eof)
                report_mismatch($sformatf("end_of_file %0b, want %0b", e, want.eof));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       input_mode_wr;
    logic [1:0] input_mode;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       stream_end;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_file;

    utf8_scoreboard sb;

    logic [7:0]  file_bytes [$];
    logic [1:0]  cur_mode;
    int unsigned sent_items;
    int unsigned burst_left;

    utf16_to_utf8_transcoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .input_mode_wr (input_mode_wr),
        .input_mode    (input_mode),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .stream_end    (stream_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_valid    (byte_valid),
        .last_of_run   (last_of_run),
        .end_of_file   (end_of_file)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one byte and hold it until the block takes it. Bursts of random
    // length alternate with idle gaps; long bursts give stretches with no gaps.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        in_valid   <= 1'b1;
        in_byte    <= b;
        stream_end <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_transfer(b, fin);
        burst_left--;
        sent_items++;
    endtask

    // Send the bytes of file_bytes; close marks the last one as end of file
    task automatic send_file(input bit close);
        foreach (file_bytes[i])
            push_byte(file_bytes[i], close && (i == int'(file_bytes.size()) - 1));
    endtask

    // Drain the block, let any result-less byte settle, then write the mode
    task automatic write_mode(input logic [1:0] m);
        in_valid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        input_mode_wr <= 1'b1;
        input_mode    <= m;
        @(posedge clk);
        input_mode_wr <= 1'b0;
        sb.set_mode(m);
        cur_mode = m;
    endtask

    function automatic void push_unit(input logic [15:0] u, input bit big);
        if (big) begin
            file_bytes.insert(file_bytes.size(), u[15:8]);
            file_bytes.insert(file_bytes.size(), u[7:0]);
        end
        else begin
            file_bytes.insert(file_bytes.size(), u[7:0]);
            file_bytes.insert(file_bytes.size(), u[15:8]);
        end
    endfunction

    function automatic void push_random_bytes(input int unsigned n);
        repeat (n) file_bytes.insert(file_bytes.size(), 8'($urandom_range(0, 255)));
    endfunction

    // Mostly well-formed UTF-16 text, with lone surrogates and edge values mixed in
    function automatic void push_text16(input bit big);
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0: push_unit(16'($urandom_range(16'h0000, 16'h007F)), big);
                1: push_unit(16'($urandom_range(16'h0080, 16'h07FF)), big);
                2: push_unit(16'($urandom_range(16'h0800, 16'hD7FF)), big);
                3: push_unit(16'($urandom_range(16'hE000, 16'hFFFF)), big);
                4, 5: begin
                    push_unit(16'($urandom_range(16'hD800, 16'hDBFF)), big);
                    push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), big);
                end
                6: push_unit(16'($urandom_range(16'hD800, 16'hDBFF)), big);
                7: push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), big);
                8: push_unit(EDGE_UNITS[$urandom_range(0, 11)], big);
                default: push_unit(16'($urandom), big);
            endcase
        end
        // odd trailing byte now and then
        if ($urandom_range(0, 4) == 0)
            push_random_bytes(1);
    endfunction

    function automatic void build_file(input logic [1:0] m);
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            push_random_bytes($urandom_range(1, 6));
            return;
        end
        case (m)
            MODE_AUTO: begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        file_bytes.insert(file_bytes.size(), BOM_FF);
                        file_bytes.insert(file_bytes.size(), BOM_FE);
                        push_text16(1'b0);
                    end
                    3, 4, 5: begin
                        file_bytes.insert(file_bytes.size(), BOM_FE);
                        file_bytes.insert(file_bytes.size(), BOM_FF);
                        push_text16(1'b1);
                    end
                    6, 7: begin
                        file_bytes.insert(file_bytes.size(), BOM_EF);
                        file_bytes.insert(file_bytes.size(), BOM_BB);
                        file_bytes.insert(file_bytes.size(), BOM_BF);
                        push_random_bytes($urandom_range(0, 5));
                    end
                    8: begin
                        // broken or truncated mark
                        case ($urandom_range(0, 2))
                            0: file_bytes.insert(file_bytes.size(), BOM_EF);
                            1: file_bytes.insert(file_bytes.size(), BOM_FF);
                            default: file_bytes.insert(file_bytes.size(), BOM_FE);
                        endcase
                        if ($urandom_range(0, 1) == 0 && file_bytes[0] == BOM_EF)
                            file_bytes.insert(file_bytes.size(), BOM_BB);
                        push_random_bytes($urandom_range(0, 3));
                    end
                    default: push_random_bytes($urandom_range(1, 5));
                endcase
            end
            MODE_LE: push_text16(1'b0);
            MODE_BE: push_text16(1'b1);
            default: push_random_bytes($urandom_range(1, 8));
        endcase
    endfunction

    // Stimulus: reset, a directed part, then random files until the item
    // target is reached; drain and give the verdict.
    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        input_mode_wr = 1'b0;
        input_mode    = MODE_AUTO;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        stream_end    = 1'b0;
        cur_mode      = MODE_AUTO;
        sent_items    = 0;
        burst_left    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Auto detection: UTF-8 mark, LE mark with a surrogate pair, BE mark
        // with a high surrogate cut short by a BMP unit, file ending in a mark
        write_mode(MODE_AUTO);
        file_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41};
        send_file(1'b1);
        file_bytes = '{8'hFF, 8'hFE, 8'h3D, 8'hD8, 8'h00, 8'hDE};
        send_file(1'b1);
        file_bytes = '{8'hFE, 8'hFF, 8'hD8, 8'h00, 8'h4E, 8'h2D};
        send_file(1'b1);
        file_bytes = '{8'hEF, 8'hBB};
        send_file(1'b1);

        // Forced LE: two high surrogates with the second on the final unit;
        // the largest unit followed by an odd byte at the end
        write_mode(MODE_LE);
        file_bytes = '{8'h00, 8'hD8, 8'h00, 8'hD8};
        send_file(1'b1);
        file_bytes = '{8'hFF, 8'hFF, 8'h7A};
        send_file(1'b1);

        write_mode(MODE_PASS);
        file_bytes = '{8'h00, 8'hFF};
        send_file(1'b1);

        write_mode(MODE_BE);
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 3) == 0)
                write_mode(2'($urandom_range(0, 3)));
            build_file(cur_mode);
            if ($urandom_range(0, 7) == 0) begin
                // stop part way through a file and restart with a mode write
                send_file(1'b0);
                write_mode(2'($urandom_range(0, 3)));
            end
            else begin
                send_file(1'b1);
            end
        end

        in_valid <= 1'b0;
        while (sb.bytes_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.bytes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: check every result transfer and stall on a pattern that
    // is redrawn at random intervals. Now and then hold off for a long
    // stretch so that the block backs up and stalls its input.
    initial
    begin : receiver
        int unsigned beats_seen;
        int unsigned hold_left;
        int unsigned next_hold_at;
        int unsigned pattern;
        int unsigned pattern_left;
        logic        stall_next;
        out_stall    = 1'b0;
        beats_seen   = 0;
        hold_left    = 0;
        next_hold_at = 60;
        pattern      = 0;
        pattern_left = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                sb.check_transfer(out_byte, byte_valid, last_of_run, end_of_file);
                beats_seen++;
            end
            if (hold_left == 0 && beats_seen >= next_hold_at) begin
                hold_left    = $urandom_range(120, 200);
                next_hold_at = beats_seen + 300;
            end
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(20, 100);
            end
            pattern_left--;
            case (pattern)
                0:       stall_next = 1'b0;
                1:       stall_next = ($urandom_range(0, 7) == 0);
                2:       stall_next = ($urandom_range(0, 1) == 0);
                default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end
            out_stall <= stall_next;
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule

@@ utf16_to_utf8_transcoder_core.f @@
src/utt_pkg.sv
src/utt_step.sv
src/utt_serial.sv
src/utf16_to_utf8_transcoder_core.sv
tb/utf16_to_utf8_transcoder_core_tb.sv
